>>> design/ussd_pkg.sv
// Shared types and constants for the unsigned shift-subtract divider.
package ussd_pkg;

    // Width of every data field on the ports
    localparam int FIELD_W = 64;
    // Default significant width of dividend and divisor
    localparam int DATA_WIDTH_DEF = 64;

    typedef struct packed {
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
        logic               divide_by_zero;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;
    } t_stat;

endpackage

>>> design/ussd_ctrl.sv
// Sequencing state machine for the shift-subtract divider.
module ussd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ussd_pkg::t_stat i_stat,
    output ussd_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_valid
);

    ussd_pkg::t_state r_state;
    ussd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ussd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_busy     = 1'b1;
        o_valid    = 1'b0;
        case (r_state)
            ussd_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ussd_pkg::S_RUN;
                end
            end
            ussd_pkg::S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_state = ussd_pkg::S_FIN;
                end
            end
            ussd_pkg::S_FIN: begin
                o_valid = 1'b1;
                n_state = ussd_pkg::S_IDLE;
            end
            default: begin
                n_state = ussd_pkg::S_IDLE;
            end
        endcase
    end

    a_load_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ussd_pkg::S_RUN)
        else $error("load did not enter the run state");

    a_last_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step && i_stat.last |=> o_valid)
        else $error("final step not followed by result strobe");

    a_fin_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> r_state == ussd_pkg::S_IDLE)
        else $error("result state lasted more than one cycle");

endmodule

>>> design/ussd_dpath.sv
// Partial remainder, quotient shift register and step counter of the divider.
module ussd_dpath #(
    parameter int DATA_WIDTH = ussd_pkg::DATA_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ussd_pkg::t_cmd  i_cmd,
    input  ussd_pkg::t_in   i_data,
    output ussd_pkg::t_stat o_stat,
    output ussd_pkg::t_out  o_result
);

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;   // dividend bits shift out, quotient bits shift in
    logic [DATA_WIDTH-1:0] r_den;
    logic                  r_den_zero;
    logic [CNT_W-1:0]      r_cnt;

    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_fits;

    // Bring in the next dividend bit; the extra top bit keeps the carry
    assign w_trial = {r_rem, r_quo[DATA_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fits  = ~w_diff[DATA_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem      <= '0;
            r_quo      <= i_data.dividend[DATA_WIDTH-1:0];
            r_den      <= i_data.divisor[DATA_WIDTH-1:0];
            r_den_zero <= (i_data.divisor[DATA_WIDTH-1:0] == '0);
            r_cnt      <= CNT_W'(DATA_WIDTH - 1);
        end else if (i_cmd.step) begin
            r_rem <= w_fits ? w_diff[DATA_WIDTH-1:0] : w_trial[DATA_WIDTH-1:0];
            r_quo <= {r_quo[DATA_WIDTH-2:0], w_fits};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_stat.last = (r_cnt == '0);

    always_comb begin
        o_result.divide_by_zero = r_den_zero;
        o_result.quotient       = r_den_zero ? '0 : ussd_pkg::FIELD_W'(r_quo);
        o_result.remainder      = r_den_zero ? '0 : ussd_pkg::FIELD_W'(r_rem);
    end

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && !r_den_zero |=> r_rem < r_den)
        else $error("partial remainder not below divisor after a step");

endmodule

>>> design/unsigned_shift_subtract_divider.sv
// Top level of the radix-2 restoring unsigned divider.
//
// Usage:
//   Present dividend and divisor on i_data and raise start. The word is
//   taken at the rising edge where start is high and busy is low; busy then
//   stays high until the result has been shown.
//   The result word appears on o_result for exactly one cycle, marked by
//   o_valid, after the load and the final step, and is taken at the edge
//   that ends the o_valid cycle. A new word can be taken at the edge
//   that ends the idle cycle following the o_valid cycle; no new word is
//   accepted while one is still in flight.
//   The steps use the single shared subtractor, which retires one
//   quotient bit per cycle under the step counter.
//   Only the low DATA_WIDTH bits of each input field are used; result fields
//   are zero above DATA_WIDTH. A zero divisor sets divide_by_zero and forces
//   quotient and remainder to zero; it still takes the full iteration time.
//   The receiver cannot stall: o_valid is a one-cycle strobe and must be
//   captured when it appears.
//   Reset (synchronous, active low) returns the controller to idle and drops
//   any item in flight; no result is produced for it.
module unsigned_shift_subtract_divider #(
    parameter int DATA_WIDTH = ussd_pkg::DATA_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ussd_pkg::t_in  i_data,
    output logic           o_valid,
    output ussd_pkg::t_out o_result
);

    ussd_pkg::t_cmd  w_cmd;
    ussd_pkg::t_stat w_stat;

    // Sequence load, DATA_WIDTH steps, then one result cycle
    ussd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Hold operands and advance the partial remainder one bit per step
    ussd_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_data   (i_data),
        .o_stat   (w_stat),
        .o_result (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepting a word");

    a_valid_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.divide_by_zero |->
            o_result.quotient == '0 && o_result.remainder == '0)
        else $error("divide by zero result not cleared");

endmodule
